// ===== rtl/oscfar_pkg.sv =====
// ----------------------------------------------------------------------------
// Ordered-statistic CFAR package
// Shared widths, defaults and register codes.
// ----------------------------------------------------------------------------
package oscfar_pkg;
  localparam int unsigned MaxTrainDef  = 16;
  localparam int unsigned MaxGuardDef  = 16;
  localparam int unsigned FrameMaxDef  = 65536;
  localparam int unsigned SampleBitsDef = 16;
  localparam int unsigned CfgWidth     = 17;
  localparam int unsigned IdxWidth     = 2;
  localparam int unsigned FieldWidth   = 16;

  typedef enum logic [IdxWidth-1:0] {
    REG_WINDOW  = 2'd0,
    REG_GUARD   = 2'd1,
    REG_PERCENT = 2'd2
  } reg_index_t;

  typedef struct packed {
    logic [4:0]  window;
    logic [4:0]  guard;
    logic [16:0] percent;
  } cfg_t;
endpackage

// ===== rtl/oscfar_select.sv =====
// ----------------------------------------------------------------------------
// Bit-serial rank selector
// Finds the value of a given rank among up to 2*MAX_TRAIN candidates, one
// bit per cycle from the most significant bit down.
// ----------------------------------------------------------------------------
module oscfar_select #(
  parameter int unsigned NCAND = 32,
  parameter int unsigned SBITS = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [NCAND-1:0][SBITS-1:0] cand,
  input  logic [NCAND-1:0]           cand_en,
  input  logic [$clog2(NCAND+1)-1:0] rank,
  output logic                       done,
  output logic [SBITS-1:0]           result
);
  import oscfar_pkg::*;

  localparam int unsigned CW = $clog2(NCAND+1);
  localparam int unsigned BW = (SBITS > 1) ? $clog2(SBITS) : 1;

  logic [NCAND-1:0][SBITS-1:0] shreg;
  logic [NCAND-1:0]            alive;
  logic [CW-1:0]               want;
  logic [BW-1:0]               bitcnt;
  logic                        busy;
  logic [CW-1:0]               zeros;
  logic                        take_one;

  always_comb begin
    zeros = '0;
    for (int i = 0; i < NCAND; i++) begin
      zeros = zeros + CW'(alive[i] & ~shreg[i][SBITS-1]);
    end
    take_one = (want >= zeros);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy   <= 1'b1;
        shreg  <= cand;
        alive  <= cand_en;
        want   <= rank;
        bitcnt <= BW'(SBITS - 1);
      end else if (busy) begin
        result <= {result[SBITS-2:0], take_one};
        for (int i = 0; i < NCAND; i++) begin
          alive[i] <= alive[i] & (shreg[i][SBITS-1] == take_one);
          shreg[i] <= shreg[i] << 1;
        end
        if (take_one) want <= want - zeros;
        if (bitcnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          bitcnt <= bitcnt - 1'b1;
        end
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_no_start_busy: assert property (@(posedge clk) disable iff (rst) busy |-> !start)
    else $error("selector restarted while busy");
  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("done held longer than one cycle");
  a_rank_live: assert property (@(posedge clk) disable iff (rst)
    (busy && alive != '0) |-> (want < CW'($countones(alive))))
    else $error("rank beyond surviving candidates");
`endif
endmodule

// ===== rtl/ordered_statistic_cfar.sv =====
// A result becomes valid after the beat that completes its look-ahead is accepted: the
// training cells are gathered one per cycle, then rank selection takes one bit per cycle.
// The input is stalled until every cell that a beat releases has been reported, so no new
// sample is taken meanwhile; output stalls also hold the block.
// Reset (rst, synchronous) restores the registers to 8, 2, 49152 and clears frame
// position and result pointer; the sample ring is not cleared.
// ----------------------------------------------------------------------------
// Ordered-statistic CFAR
// Holds the sample ring, gathers training cells per cell under test and
// drives the bit-serial selector.
// ----------------------------------------------------------------------------
module ordered_statistic_cfar #(
  parameter int unsigned MAX_TRAIN   = oscfar_pkg::MaxTrainDef,
  parameter int unsigned MAX_GUARD   = oscfar_pkg::MaxGuardDef,
  parameter int unsigned FRAME_MAX   = oscfar_pkg::FrameMaxDef,
  parameter int unsigned SAMPLE_BITS = oscfar_pkg::SampleBitsDef
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [oscfar_pkg::IdxWidth-1:0]     cfg_index,
  input  logic [oscfar_pkg::CfgWidth-1:0]     cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [oscfar_pkg::FieldWidth-1:0]   sample,
  input  logic                                frame_end,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [oscfar_pkg::FieldWidth-1:0]   estimate,
  output logic                                has_estimate,
  output logic [oscfar_pkg::FieldWidth-1:0]   cell_index,
  output logic                                last
);
  import oscfar_pkg::*;

  localparam int unsigned LOOK  = MAX_TRAIN + MAX_GUARD - 1;
  localparam int unsigned DEPTH = 2 * LOOK + 1;
  localparam int unsigned NCAND = 2 * MAX_TRAIN;
  localparam int unsigned PW    = $clog2(FRAME_MAX);
  localparam int unsigned CW    = $clog2(NCAND + 1);
  localparam int unsigned SBITS = SAMPLE_BITS;
  localparam int unsigned TW    = $clog2(MAX_TRAIN + 1);
  localparam int unsigned GW    = $clog2(MAX_GUARD + 1);
  localparam int unsigned LW    = $clog2(LOOK + 1);
  localparam int unsigned SW    = $clog2(DEPTH);

  typedef enum logic [2:0] {S_IDLE, S_CHECK, S_GATHER, S_START, S_WAIT, S_OUT} state_t;

  cfg_t                         cfg;
  state_t                       state;
  logic [SBITS-1:0]             ring [DEPTH];
  logic [SBITS-1:0]             rd_data;
  logic                         rd_en;
  logic [SW-1:0]                rd_addr;
  logic                         gat_en;
  logic [CW-1:0]                gcnt;
  logic [PW-1:0]                pos;
  logic [SW-1:0]                pos_slot;
  logic [PW-1:0]                top;
  logic [PW:0]                  nxt;
  logic [SW-1:0]                nxt_slot;
  logic                         fend;
  logic [TW-1:0]                w_sat;
  logic [GW-1:0]                g_sat;
  logic [LW-1:0]                look;
  logic [NCAND-1:0][SBITS-1:0]  cand;
  logic [NCAND-1:0]             cand_en;
  logic [CW-1:0]                n_cnt;
  logic [CW+17-1:0]             prod;
  logic [CW-1:0]                rank;
  logic                         sel_start;
  logic                         sel_done;
  logic [SBITS-1:0]             sel_res;
  logic                         ready_cell;
  logic [SBITS-1:0]             smp_w;
  logic                         in_acc;

  assign w_sat = (cfg.window < 5'd1) ? TW'(1) :
                 ({27'd0, cfg.window} > MAX_TRAIN) ? TW'(MAX_TRAIN) : TW'(cfg.window);
  assign g_sat = (cfg.guard < 5'd1) ? GW'(1) :
                 ({27'd0, cfg.guard} > MAX_GUARD) ? GW'(MAX_GUARD) : GW'(cfg.guard);
  assign look  = LW'(w_sat) + LW'(g_sat) - LW'(1);

  assign in_stall = (state != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign smp_w    = SBITS'(sample);

  assign ready_cell = (nxt <= {1'b0, top}) &&
                      (fend || (nxt + (PW+1)'(look) <= {1'b0, top}));

  // Training cell gcnt: even counts lie before the cell under test, odd ones after it.
  always_comb begin
    logic [CW-1:0] half;
    logic [PW:0]   dpos;
    logic [SW:0]   dsl;
    logic [SW:0]   addr_w;
    half = gcnt >> 1;
    dpos = (PW+1)'(g_sat) + (PW+1)'(half);
    dsl  = (SW+1)'(g_sat) + (SW+1)'(half);
    if (gcnt[0] == 1'b0) begin
      gat_en = (half < CW'(w_sat)) && (nxt >= dpos);
      if ({1'b0, nxt_slot} >= dsl) begin
        addr_w = {1'b0, nxt_slot} - dsl;
      end else begin
        addr_w = {1'b0, nxt_slot} + (SW+1)'(DEPTH) - dsl;
      end
    end else begin
      gat_en = (half < CW'(w_sat)) && (nxt + dpos <= {1'b0, top});
      addr_w = {1'b0, nxt_slot} + dsl;
      if (addr_w >= (SW+1)'(DEPTH)) addr_w = addr_w - (SW+1)'(DEPTH);
    end
    rd_addr = addr_w[SW-1:0];
  end

  always_comb begin
    prod = (CW+17)'(cfg.percent) * (CW+17)'(n_cnt);
    rank = CW'(prod >> 16);
    if (rank != '0) rank = rank - 1'b1;
    if (n_cnt != '0 && rank > n_cnt - 1'b1) rank = n_cnt - 1'b1;
  end

  assign sel_start = (state == S_START);

  always_ff @(posedge clk) begin
    if (in_acc) ring[pos_slot] <= smp_w;
    rd_data <= ring[rd_addr];
    rd_en   <= gat_en;
  end

  oscfar_select #(.NCAND(NCAND), .SBITS(SBITS)) u_select (
    .clk(clk), .rst(rst), .start(sel_start), .cand(cand), .cand_en(cand_en),
    .rank(rank), .done(sel_done), .result(sel_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      pos       <= '0;
      pos_slot  <= '0;
      nxt       <= '0;
      nxt_slot  <= '0;
      out_valid <= 1'b0;
      cfg.window  <= 5'd8;
      cfg.guard   <= 5'd2;
      cfg.percent <= 17'd49152;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_WINDOW:  cfg.window  <= cfg_data[4:0];
          REG_GUARD:   cfg.guard   <= cfg_data[4:0];
          REG_PERCENT: cfg.percent <= cfg_data[16:0];
          default: ;
        endcase
      end
      unique case (state)
        S_IDLE: begin
          if (in_acc) begin
            top   <= pos;
            fend  <= frame_end || (pos >= PW'(FRAME_MAX - 1));
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (ready_cell) begin
            cell_index <= FieldWidth'(nxt);
            last       <= fend && (nxt == {1'b0, top});
            gcnt       <= '0;
            n_cnt      <= '0;
            state      <= S_GATHER;
          end else begin
            if (fend) begin
              pos      <= '0;
              pos_slot <= '0;
              nxt      <= '0;
              nxt_slot <= '0;
            end else begin
              pos      <= top + 1'b1;
              pos_slot <= (pos_slot == SW'(DEPTH - 1)) ? '0 : pos_slot + 1'b1;
            end
            state <= S_IDLE;
          end
        end
        S_GATHER: begin
          if (gcnt != '0) begin
            cand    <= {cand[NCAND-2:0], rd_data};
            cand_en <= {cand_en[NCAND-2:0], rd_en};
            n_cnt   <= n_cnt + CW'(rd_en);
          end
          if (gcnt == CW'(NCAND)) begin
            state <= S_START;
          end else begin
            gcnt <= gcnt + 1'b1;
          end
        end
        S_START: begin
          has_estimate <= (n_cnt != '0);
          state        <= S_WAIT;
        end
        S_WAIT: begin
          if (sel_done) begin
            estimate  <= has_estimate ? FieldWidth'(sel_res) : '0;
            out_valid <= 1'b1;
            state     <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_stall) begin
            out_valid <= 1'b0;
            nxt       <= nxt + 1'b1;
            nxt_slot  <= (nxt_slot == SW'(DEPTH - 1)) ? '0 : nxt_slot + 1'b1;
            state     <= S_CHECK;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_out_in_state: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (state == S_OUT))
    else $error("result shown outside output state");
  a_nxt_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_WAIT) |-> (nxt <= {1'b0, top}))
    else $error("cell reported beyond newest sample");
  a_no_est: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !has_estimate) |-> (estimate == '0))
    else $error("estimate without training cells");
`endif
endmodule

// ===== test/testbench.sv =====
// ----------------------------------------------------------------------------
// Ordered-statistic CFAR testbench
// Sends frames of power samples through the block and compares every result
// with an in-bench estimator that keeps its own sample ring and registers.
// The run covers directed extremes, out-of-range and boundary register
// settings, and random frames with random idling on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import oscfar_pkg::*;

  localparam int unsigned RingDepth = 63;
  localparam int unsigned MaxCells  = 32;
  localparam int unsigned DogLimit  = 4000;
  localparam int unsigned SettleCyc = 40;

  typedef struct packed {
    logic [15:0] estimate;
    logic        has_estimate;
    logic [15:0] cell_index;
    logic        last;
  } cell_result_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [IdxWidth-1:0]   cfg_index;
  logic [CfgWidth-1:0]   cfg_data;
  logic                  in_valid;
  logic                  in_stall;
  logic [FieldWidth-1:0] sample;
  logic                  frame_end;
  logic                  out_valid;
  logic                  out_stall;
  logic [FieldWidth-1:0] estimate;
  logic                  has_estimate;
  logic [FieldWidth-1:0] cell_index;
  logic                  last;

  logic [4:0]   train_reg;
  logic [4:0]   guard_reg;
  logic [16:0]  pct_reg;
  logic [15:0]  ring [RingDepth];
  int unsigned  frame_pos;
  int unsigned  next_cell;

  cell_result_t pending_cells[$];
  int unsigned  send_idle_pct;
  int unsigned  recv_stall_pct;
  int unsigned  fail_cnt;
  int unsigned  beats_in;
  int unsigned  beats_out;
  int unsigned  dog_cnt;

  ordered_statistic_cfar i_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .sample       (sample),
    .frame_end    (frame_end),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .estimate     (estimate),
    .has_estimate (has_estimate),
    .cell_index   (cell_index),
    .last         (last)
  );

  always #5 clk = ~clk;

  function automatic int unsigned clip(int unsigned v, int unsigned lo, int unsigned hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic cell_result_t estimate_cell(int unsigned c, int unsigned top);
    cell_result_t r;
    int unsigned vals[$];
    int unsigned w;
    int unsigned g;
    longint unsigned k;
    w = clip(train_reg, 1, MaxTrainDef);
    g = clip(guard_reg, 1, MaxGuardDef);
    for (int unsigned d = g; d < g + w; d++) begin
      if (c >= d) vals.push_back(ring[(c - d) % RingDepth]);
      if (c + d <= top) vals.push_back(ring[(c + d) % RingDepth]);
    end
    r = '0;
    r.cell_index = c[15:0];
    if (vals.size() != 0) begin
      vals.sort();
      k = (longint'(pct_reg) * vals.size()) >> 16;
      if (k > 0) k--;
      if (k > vals.size() - 1) k = vals.size() - 1;
      r.estimate = vals[k][15:0];
      r.has_estimate = 1'b1;
    end
    return r;
  endfunction

  task automatic predict_cells(logic [15:0] s, logic fe);
    int unsigned p;
    int unsigned look;
    int unsigned count;
    bit          ends;
    cell_result_t r;
    p = frame_pos;
    ends = fe || (p >= FrameMaxDef - 1);
    look = clip(train_reg, 1, MaxTrainDef) + clip(guard_reg, 1, MaxGuardDef) - 1;
    count = 0;
    ring[p % RingDepth] = s;
    while (next_cell <= p && (ends || next_cell + look <= p) && count < MaxCells) begin
      r = estimate_cell(next_cell, p);
      r.last = ends && (next_cell == p);
      pending_cells.push_back(r);
      next_cell++;
      count++;
    end
    if (ends) begin
      frame_pos = 0;
      next_cell = 0;
    end else begin
      frame_pos = p + 1;
    end
  endtask

  task automatic send_beat(logic [15:0] s, logic fe);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    sample    <= s;
    frame_end <= fe;
    do @(posedge clk); while (in_stall);
    beats_in++;
    predict_cells(s, fe);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_cells.size() != 0) @(posedge clk);
    repeat (SettleCyc) @(posedge clk);
  endtask

  task automatic write_reg(reg_index_t idx, logic [16:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(posedge clk);
    case (idx)
      REG_WINDOW:  train_reg = v[4:0];
      REG_GUARD:   guard_reg = v[4:0];
      REG_PERCENT: pct_reg   = v;
      default: ;
    endcase
  endtask

  task automatic set_regs(logic [4:0] w, logic [4:0] g, logic [16:0] pc);
    write_reg(REG_WINDOW, 17'(w));
    write_reg(REG_GUARD, 17'(g));
    write_reg(REG_PERCENT, pc);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [15:0] pick_sample();
    case ($urandom_range(3))
      0: return 16'($urandom_range(7));
      1: return 16'hFFFF - 16'($urandom_range(3));
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_frame(int unsigned len);
    for (int unsigned i = 0; i < len; i++) send_beat(pick_sample(), i == len - 1);
  endtask

  task automatic test_directed();
    logic [15:0] pat [12] = '{16'h0000, 16'hFFFF, 16'hAAAA, 16'h5555, 16'h0001, 16'h8000,
                              16'h7FFF, 16'hFFFE, 16'h0000, 16'h00FF, 16'hFF00, 16'hFFFF};
    send_beat(16'hFFFF, 1'b1);
    for (int i = 0; i < 12; i++) send_beat(pat[i], i == 11);
    wait_idle();
  endtask

  task automatic test_register_extremes();
    set_regs(5'd0, 5'd0, 17'd0);
    send_frame(6);
    wait_idle();
    set_regs(5'd31, 5'd31, 17'h1FFFF);
    send_frame(40);
    wait_idle();
    set_regs(5'd16, 5'd16, 17'd65536);
    send_frame(70);
    wait_idle();
    set_regs(5'd1, 5'd1, 17'd1);
    send_frame(8);
    wait_idle();
    set_regs(5'd4, 5'd16, 17'd32768);
    send_frame(5);
    send_frame(2);
    wait_idle();
  endtask

  task automatic test_random(int unsigned items);
    int unsigned sent;
    int unsigned len;
    sent = 0;
    while (sent < items) begin
      if ($urandom_range(3) == 0) begin
        wait_idle();
        set_regs($urandom_range(9) == 0 ? 5'($urandom_range(31)) : 5'($urandom_range(16, 1)),
                 $urandom_range(9) == 0 ? 5'($urandom_range(31)) : 5'($urandom_range(16, 1)),
                 $urandom_range(5) == 0 ? 17'($urandom_range(131071)) :
                                          17'($urandom_range(65536)));
      end
      len = ($urandom_range(9) == 0) ? $urandom_range(80, 30) : $urandom_range(24, 1);
      send_frame(len);
      sent += len;
    end
    wait_idle();
  endtask

  always @(posedge clk) begin
    cell_result_t want;
    if (out_valid && !out_stall) begin
      beats_out++;
      if (pending_cells.size() == 0) begin
        $display("%0t: result with none expected: cell %0d est %0d", $time, cell_index, estimate);
        fail_cnt++;
      end else begin
        want = pending_cells.pop_front();
        if (want.estimate !== estimate) begin
          $display("%0t: estimate exp %0d got %0d", $time, want.estimate, estimate);
          fail_cnt++;
        end
        if (want.has_estimate !== has_estimate) begin
          $display("%0t: has_estimate exp %0d got %0d", $time, want.has_estimate, has_estimate);
          fail_cnt++;
        end
        if (want.cell_index !== cell_index) begin
          $display("%0t: cell_index exp %0d got %0d", $time, want.cell_index, cell_index);
          fail_cnt++;
        end
        if (want.last !== last) begin
          $display("%0t: last exp %0d got %0d", $time, want.last, last);
          fail_cnt++;
        end
      end
    end
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      dog_cnt <= 0;
    end else begin
      dog_cnt <= dog_cnt + 1;
      if (dog_cnt >= DogLimit) begin
        $display("%0t: no beat accepted for %0d cycles", $time, DogLimit);
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin
    clk = 1'b0;
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= REG_WINDOW;
    cfg_data <= '0;
    in_valid <= 1'b0;
    sample <= '0;
    frame_end <= 1'b0;
    out_stall <= 1'b0;
    train_reg = 5'd8;
    guard_reg = 5'd2;
    pct_reg = 17'd49152;
    frame_pos = 0;
    next_cell = 0;
    fail_cnt = 0;
    beats_in = 0;
    beats_out = 0;
    dog_cnt = 0;
    send_idle_pct = 14;
    recv_stall_pct = 48;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_register_extremes();
    test_random(120);
    send_idle_pct = 48;
    recv_stall_pct = 14;
    test_random(120);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    test_random(120);
    if (pending_cells.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, pending_cells.size());
      fail_cnt++;
    end
    $display("Sent %0d samples and checked %0d cell results across", beats_in, beats_out);
    $display("boundary, out-of-range and random register settings with varied idling.");
    if (fail_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
